[src/assert_macros.svh]
// Assertion macros shared by the demosaic RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BDE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BDE_ASSERT_IMPLY(lbl, ante, cons)
`define BDE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/bde_pkg.sv]
// Shared types, constants and arithmetic helpers for the Bayer demosaic.
`timescale 1ns / 1ps
package bde_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int ROW_BUFFERS = 4;
  localparam int PIX_W       = 8;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int LANE_W      = $clog2(ROW_BUFFERS);
  localparam int WORD_W      = PIX_W * ROW_BUFFERS;
  localparam int FW_W        = 12;
  localparam int FH_W        = 16;
  localparam int SUM_W       = PIX_W + 2;

  typedef enum logic [1:0] {
    REG_PATTERN   = 2'd0,
    REG_INTERLACE = 2'd1,
    REG_WIDTH     = 2'd2,
    REG_HEIGHT    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLR_RED   = 2'd0,
    CLR_GREEN = 2'd1,
    CLR_BLUE  = 2'd2
  } colour_t;

  localparam colour_t TILE_MAP [4][4] = '{
    '{CLR_RED,   CLR_GREEN, CLR_GREEN, CLR_BLUE},
    '{CLR_GREEN, CLR_RED,   CLR_BLUE,  CLR_GREEN},
    '{CLR_BLUE,  CLR_GREEN, CLR_GREEN, CLR_RED},
    '{CLR_GREEN, CLR_BLUE,  CLR_RED,   CLR_GREEN}
  };

  typedef struct packed {
    logic                 valid;
    logic [COL_W-1:0]     col;
    logic [LANE_W-1:0]    lane;
    logic [PIX_W-1:0]     data;
  } wr_t;

  typedef struct packed {
    logic                 emit;
    logic                 done;
    logic [COL_W-1:0]     x;
    logic [LANE_W-1:0]    ylane;
    colour_t              c;
    colour_t              hc;
    logic [3:0]           ok;     // {bottom, top, right, left}
    wr_t                  wr;
  } s1_t;

  // Exact floor(s / 3) for s below 768.
  function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] s);
    logic [SUM_W+9:0] p;
    p = {10'd0, s} * (SUM_W + 10)'(683);
    return p[PIX_W+10:11];
  endfunction

  function automatic logic [PIX_W-1:0] avg_n(input logic [SUM_W-1:0] s,
                                             input logic [2:0] n);
    logic [SUM_W-1:0] q;
    case (n)
      3'd1:    q = s;
      3'd2:    q = s >> 1;
      3'd3:    q = {2'b00, div3(s)};
      3'd4:    q = s >> 2;
      default: q = '0;
    endcase
    return q[PIX_W-1:0];
  endfunction

  // Four-point average that drops a single outlier when one stands apart.
  function automatic logic [PIX_W-1:0] robust(input logic [4*PIX_W-1:0] v,
                                              input logic [SUM_W-1:0] s,
                                              input logic [2:0] n,
                                              input logic [PIX_W-1:0] avg);
    logic [3:0]        up;
    logic [2:0]        above;
    logic [PIX_W-1:0]  single;
    logic [PIX_W-1:0]  res;
    single = '0;
    for (int i = 0; i < 4; i++) up[i] = v[i*PIX_W +: PIX_W] > avg;
    above = 3'(up[0]) + 3'(up[1]) + 3'(up[2]) + 3'(up[3]);
    for (int i = 0; i < 4; i++)
      if (up[i] == (above == 3'd1)) single = v[i*PIX_W +: PIX_W];
    if (n != 3'd4 || above == 3'd0 || above == 3'd2 || above == 3'd4) res = avg;
    else res = div3(s - {2'b00, single});
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] patch(input logic [WORD_W-1:0] word,
                                              input logic [COL_W-1:0] col,
                                              input wr_t wr);
    logic [WORD_W-1:0] w;
    w = word;
    if (wr.valid && wr.col == col) w[wr.lane*PIX_W +: PIX_W] = wr.data;
    return w;
  endfunction

endpackage

[src/bde_ram.sv]
// Generic two-read-port RAM with lane write enables and registered read.
`timescale 1ns / 1ps
module bde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int LANES = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [LANES-1:0]         lane_en,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  localparam int LW = WIDTH / LANES;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int l = 0; l < LANES; l++)
        if (lane_en[l]) mem[waddr][l*LW +: LW] <= wdata[l*LW +: LW];
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end
endmodule

[src/bayer_demosaic_edge_aware.sv]
// Top level of the streaming edge-aware Bayer demosaic.
`timescale 1ns / 1ps
// The block takes raw 8-bit Bayer samples, one per transfer, in storage order
// and returns one RGB pixel per site in raster order, two rows behind the
// input. After a full frame has gone in, drain transfers (in_tuser high) push
// out the last two rows; the final pixel carries out_tlast. Configuration
// (tile pattern, interlaced storage, width, height) must be written through
// the cfg port only while no work is in flight; the block itself does not
// enforce this. One transfer is accepted every clock cycle when the output
// side keeps up. The rate is set by the row memory: one word per
// column holds that column of all four row buffers, and its two read ports
// fetch columns x and x+1 for every pixel while the write port stores the new
// sample; column x-1 is kept from the previous pixel. Reads that meet a write
// to the same column are patched by forwarding. The memory needs no clearing
// pass: every entry that a pixel uses has been written before it is read.
// Each stage of the five-stage pipeline has its own valid bit and moves when
// the stage after it is free, so bubbles close up under back-pressure.
module bayer_demosaic_edge_aware
  import bde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] raw_sample
  input  logic                 in_tuser,   // [0] action (1 = drain)
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic                 out_tlast,  // frame_done
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [15:0]          cfg_wdata
);
`include "assert_macros.svh"

  // Configuration registers.
  logic [1:0]      pattern_r;
  logic            interlace_r;
  logic [FW_W-1:0] fwidth_r;
  logic [FH_W-1:0] fheight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= '0;
      interlace_r <= 1'b0;
      fwidth_r    <= FW_W'(640);
      fheight_r   <= FH_W'(480);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_PATTERN:   pattern_r   <= cfg_wdata[1:0];
        REG_INTERLACE: interlace_r <= cfg_wdata[0];
        REG_WIDTH:     fwidth_r    <= cfg_wdata[FW_W-1:0];
        REG_HEIGHT:    fheight_r   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Pipeline handshake. Each stage advances when the next one is empty or
  // moving on.
  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic ce1, ce2, ce3, ce4, ceo;
  logic in_fire;

  assign ceo       = !vo_r || out_tready;
  assign ce4       = !v4_r || ceo;
  assign ce3       = !v3_r || ce4;
  assign ce2       = !v2_r || ce3;
  assign ce1       = !v1_r || ce2;
  assign in_tready = ce1;
  assign in_fire   = in_tvalid && in_tready;

  // Stream position counters.
  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [FH_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;

  logic [FW_W-1:0]  w_use;
  logic [FH_W-1:0]  h_use;
  logic             complete;
  logic [FW_W-1:0]  in_col_inc, out_col_inc;
  logic [FH_W:0]    out_row_inc;
  logic [COL_W-1:0] half;
  logic [FW_W-1:0]  wcol;
  logic             st0_done;
  s1_t              s1_nxt;

  always_comb begin
    w_use = fwidth_r;
    if (fwidth_r < FW_W'(2)) w_use = FW_W'(2);
    if (fwidth_r > FW_W'(MAX_WIDTH)) w_use = FW_W'(MAX_WIDTH);
    h_use       = (fheight_r < FH_W'(2)) ? FH_W'(2) : fheight_r;
    complete    = in_row_r >= h_use;
    in_col_inc  = {1'b0, in_col_r} + 1'b1;
    out_col_inc = {1'b0, out_col_r} + 1'b1;
    out_row_inc = {1'b0, out_row_r} + 1'b1;
    half        = w_use[FW_W-1:1];
    if (!interlace_r)        wcol = {1'b0, in_col_r};
    else if (in_col_r < half) wcol = {in_col_r, 1'b1};
    else                      wcol = {in_col_r - half, 1'b0};

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    st0_done    = 1'b0;

    s1_nxt          = '0;
    s1_nxt.x        = out_col_r;
    s1_nxt.ylane    = out_row_r[LANE_W-1:0];
    s1_nxt.c        = TILE_MAP[pattern_r][{~out_row_r[0], ~out_col_r[0]}];
    s1_nxt.hc       = TILE_MAP[pattern_r][{~out_row_r[0], out_col_r[0]}];
    s1_nxt.ok[0]    = out_col_r != '0;
    s1_nxt.ok[1]    = out_col_inc < w_use;
    s1_nxt.ok[2]    = out_row_r != '0;
    s1_nxt.ok[3]    = out_row_inc < {1'b0, h_use};
    s1_nxt.wr.col   = wcol[COL_W-1:0];
    s1_nxt.wr.lane  = in_row_r[LANE_W-1:0];
    s1_nxt.wr.data  = in_tdata;

    if (!in_tuser) begin
      if (!complete) begin
        s1_nxt.wr.valid = !wcol[FW_W-1];
        s1_nxt.emit     = in_row_r >= FH_W'(2);
        if (in_col_inc >= w_use) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + 1'b1;
        end else begin
          in_col_nxt = in_col_inc[COL_W-1:0];
        end
      end
    end else if (complete) begin
      s1_nxt.emit = 1'b1;
      st0_done    = (out_col_inc >= w_use) && (out_row_inc >= {1'b0, h_use});
    end
    s1_nxt.done = st0_done;

    if (s1_nxt.emit) begin
      if (st0_done) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (out_col_inc >= w_use) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (in_fire) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Row memory: one word per column, one byte lane per row buffer.
  logic [WORD_W-1:0]      rd_a, rd_b;
  logic [ROW_BUFFERS-1:0] lane_en;

  always_comb begin
    lane_en = '0;
    lane_en[s1_nxt.wr.lane] = 1'b1;
  end

  bde_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WIDTH),
    .LANES (ROW_BUFFERS)
  ) u_row_ram (
    .clk     (clk),
    .we      (in_fire && s1_nxt.wr.valid),
    .lane_en (lane_en),
    .waddr   (s1_nxt.wr.col),
    .wdata   ({ROW_BUFFERS{in_tdata}}),
    .re      (ce1),
    .raddr_a (out_col_r),
    .raddr_b (out_col_r + 1'b1),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Stage 1: the memory words are patched with the write made in the same
  // cycle, and column x-1 comes from the held word of the previous pixel.
  s1_t               s1_r;
  logic [WORD_W-1:0] hold_r;
  logic [COL_W-1:0]  hold_tag_r;
  logic [WORD_W-1:0] col_l, col_m, col_r;
  logic [LANE_W-1:0] lt, lm, lb;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (ce1) v1_r <= in_fire;
  end

  always_ff @(posedge clk) begin
    if (ce1) s1_r <= s1_nxt;
  end

  always_comb begin
    col_m = patch(rd_a, s1_r.x, s1_r.wr);
    col_r = patch(rd_b, s1_r.x + 1'b1, s1_r.wr);
    col_l = patch(hold_r, hold_tag_r, s1_r.wr);
    lt    = s1_r.ylane - 1'b1;
    lm    = s1_r.ylane;
    lb    = s1_r.ylane + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_tag_r <= '0;
    end else if (ce2 && v1_r) begin
      if (s1_r.emit) hold_tag_r <= s1_r.x;
    end
  end

  always_ff @(posedge clk) begin
    if (ce2 && v1_r) hold_r <= s1_r.emit ? col_m : col_l;
  end

  // Stage 2: the 3x3 neighborhood.
  logic [PIX_W-1:0] s2_ctr_r, s2_l_r, s2_r_r, s2_t_r, s2_b_r;
  logic [PIX_W-1:0] s2_tl_r, s2_tr_r, s2_bl_r, s2_br_r;
  logic [3:0]       s2_ok_r;
  colour_t          s2_c_r, s2_hc_r;
  logic             s2_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (ce2) v2_r <= v1_r && s1_r.emit;
  end

  always_ff @(posedge clk) begin
    if (ce2) begin
      s2_ctr_r  <= col_m[lm*PIX_W +: PIX_W];
      s2_l_r    <= col_l[lm*PIX_W +: PIX_W];
      s2_r_r    <= col_r[lm*PIX_W +: PIX_W];
      s2_t_r    <= col_m[lt*PIX_W +: PIX_W];
      s2_b_r    <= col_m[lb*PIX_W +: PIX_W];
      s2_tl_r   <= col_l[lt*PIX_W +: PIX_W];
      s2_tr_r   <= col_r[lt*PIX_W +: PIX_W];
      s2_bl_r   <= col_l[lb*PIX_W +: PIX_W];
      s2_br_r   <= col_r[lb*PIX_W +: PIX_W];
      s2_ok_r   <= s1_r.ok;
      s2_c_r    <= s1_r.c;
      s2_hc_r   <= s1_r.hc;
      s2_done_r <= s1_r.done;
    end
  end

  // Stage 2 logic: pair averages, point sums and squared gradients.
  logic [3:0]         gok, dok;
  logic [4*PIX_W-1:0] gv, dv;
  logic [SUM_W-1:0]   gsum, dsum, hsum, vsum;
  logic [2:0]         gn, dn;
  logic signed [PIX_W:0]   dh, dvd;
  logic signed [2*PIX_W+1:0] hsq, vsq;

  always_comb begin
    gv   = {s2_b_r, s2_t_r, s2_r_r, s2_l_r};
    gok  = s2_ok_r;
    dv   = {s2_tr_r, s2_bl_r, s2_tl_r, s2_br_r};
    dok  = {s2_ok_r[1] & s2_ok_r[2], s2_ok_r[0] & s2_ok_r[3],
            s2_ok_r[0] & s2_ok_r[2], s2_ok_r[1] & s2_ok_r[3]};
    gsum = '0;
    dsum = '0;
    gn   = '0;
    dn   = '0;
    for (int i = 0; i < 4; i++) begin
      if (gok[i]) begin
        gsum = gsum + SUM_W'(gv[i*PIX_W +: PIX_W]);
        gn   = gn + 1'b1;
      end
      if (dok[i]) begin
        dsum = dsum + SUM_W'(dv[i*PIX_W +: PIX_W]);
        dn   = dn + 1'b1;
      end
    end
    hsum = (gok[0] ? SUM_W'(s2_l_r) : '0) + (gok[1] ? SUM_W'(s2_r_r) : '0);
    vsum = (gok[2] ? SUM_W'(s2_t_r) : '0) + (gok[3] ? SUM_W'(s2_b_r) : '0);
    dh   = $signed({1'b0, s2_r_r}) - $signed({1'b0, s2_l_r});
    dvd  = $signed({1'b0, s2_b_r}) - $signed({1'b0, s2_t_r});
    hsq  = dh * dh;
    vsq  = dvd * dvd;
  end

  // Stage 3.
  logic [PIX_W-1:0]   s3_ctr_r, s3_hav_r, s3_vav_r;
  logic [4*PIX_W-1:0] s3_gv_r, s3_dv_r;
  logic [SUM_W-1:0]   s3_gsum_r, s3_dsum_r;
  logic [2:0]         s3_gn_r, s3_dn_r;
  logic [2*PIX_W:0]   s3_hd_r, s3_vd_r;
  colour_t            s3_c_r, s3_hc_r;
  logic               s3_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (ce3) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (ce3) begin
      s3_ctr_r  <= s2_ctr_r;
      s3_hav_r  <= avg_n(hsum, {1'b0, 2'(gok[0]) + 2'(gok[1])});
      s3_vav_r  <= avg_n(vsum, {1'b0, 2'(gok[2]) + 2'(gok[3])});
      s3_gv_r   <= gv;
      s3_dv_r   <= dv;
      s3_gsum_r <= gsum;
      s3_dsum_r <= dsum;
      s3_gn_r   <= gn;
      s3_dn_r   <= dn;
      s3_hd_r   <= hsq[2*PIX_W:0];
      s3_vd_r   <= vsq[2*PIX_W:0];
      s3_c_r    <= s2_c_r;
      s3_hc_r   <= s2_hc_r;
      s3_done_r <= s2_done_r;
    end
  end

  // Stage 3 logic: averages and the edge decision for green.
  logic [PIX_W-1:0] gavg, davg, gedge_val;
  logic             gedge_v;
  logic [PIX_W:0]   pair_sum;

  always_comb begin
    gavg      = avg_n(s3_gsum_r, s3_gn_r);
    davg      = avg_n(s3_dsum_r, s3_dn_r);
    gedge_v   = 1'b0;
    pair_sum  = '0;
    if (s3_gn_r == 3'd4) begin
      if ({1'b0, s3_hd_r} > {s3_vd_r, 1'b0}) begin
        gedge_v  = 1'b1;
        pair_sum = {1'b0, s3_gv_r[3*PIX_W +: PIX_W]} + {1'b0, s3_gv_r[2*PIX_W +: PIX_W]};
      end else if ({1'b0, s3_vd_r} > {s3_hd_r, 1'b0}) begin
        gedge_v  = 1'b1;
        pair_sum = {1'b0, s3_gv_r[PIX_W +: PIX_W]} + {1'b0, s3_gv_r[0 +: PIX_W]};
      end
    end
    gedge_val = pair_sum[PIX_W:1];
  end

  // Stage 4.
  logic [PIX_W-1:0]   s4_ctr_r, s4_hav_r, s4_vav_r, s4_gavg_r, s4_davg_r, s4_gedge_r;
  logic [4*PIX_W-1:0] s4_gv_r, s4_dv_r;
  logic [SUM_W-1:0]   s4_gsum_r, s4_dsum_r;
  logic [2:0]         s4_gn_r, s4_dn_r;
  logic               s4_gedge_v_r;
  colour_t            s4_c_r, s4_hc_r;
  logic               s4_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (ce4) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (ce4) begin
      s4_ctr_r     <= s3_ctr_r;
      s4_hav_r     <= s3_hav_r;
      s4_vav_r     <= s3_vav_r;
      s4_gavg_r    <= gavg;
      s4_davg_r    <= davg;
      s4_gedge_r   <= gedge_val;
      s4_gedge_v_r <= gedge_v;
      s4_gv_r      <= s3_gv_r;
      s4_dv_r      <= s3_dv_r;
      s4_gsum_r    <= s3_gsum_r;
      s4_dsum_r    <= s3_dsum_r;
      s4_gn_r      <= s3_gn_r;
      s4_dn_r      <= s3_dn_r;
      s4_c_r       <= s3_c_r;
      s4_hc_r      <= s3_hc_r;
      s4_done_r    <= s3_done_r;
    end
  end

  // Stage 4 logic: outlier rejection and channel assembly.
  logic [PIX_W-1:0] gfin, dfin, red, green, blue;

  always_comb begin
    gfin  = s4_gedge_v_r ? s4_gedge_r : robust(s4_gv_r, s4_gsum_r, s4_gn_r, s4_gavg_r);
    dfin  = robust(s4_dv_r, s4_dsum_r, s4_dn_r, s4_davg_r);
    red   = '0;
    green = '0;
    blue  = '0;
    case (s4_c_r)
      CLR_GREEN: begin
        green = s4_ctr_r;
        if (s4_hc_r == CLR_RED) begin
          red  = s4_hav_r;
          blue = s4_vav_r;
        end else begin
          blue = s4_hav_r;
          red  = s4_vav_r;
        end
      end
      CLR_RED: begin
        red   = s4_ctr_r;
        green = gfin;
        blue  = dfin;
      end
      CLR_BLUE: begin
        blue  = s4_ctr_r;
        green = gfin;
        red   = dfin;
      end
      default: ;
    endcase
  end

  // Output register.
  logic [23:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (ceo) vo_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (ceo) begin
      out_data_r <= {blue, green, red};
      out_last_r <= s4_done_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The held column must be the left neighbor of every pixel past column 0.
  `BDE_ASSERT_IMPLY(a_win_tag, v1_r && s1_r.emit && s1_r.x != '0, hold_tag_r == s1_r.x - 1'b1)
  // The end of a frame returns the stream counters to the start.
  `BDE_ASSERT_NEXT(a_done_clr, in_fire && st0_done, in_row_r == '0 && out_row_r == '0)
  // Input is held off only while the first stage is occupied.
  `BDE_ASSERT_IMPLY(a_ready, !in_tready, v1_r)

endmodule
